// ===== rtl/core/prpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpc_pkg
// Shared types and codes for the pull-style CSR PageRank engine.
// ----------------------------------------------------------------------------
package prpc_pkg;

    localparam int VALUE_W = 14;
    localparam int INDEX_W = 13;

    localparam logic [1:0] CMD_LOAD_ROW  = 2'd0;
    localparam logic [1:0] CMD_LOAD_EDGE = 2'd1;
    localparam logic [1:0] CMD_RUN       = 2'd2;
    localparam logic [1:0] CMD_READ      = 2'd3;

    localparam logic [1:0] REG_VERTEX_COUNT    = 2'd0;
    localparam logic [1:0] REG_EDGE_COUNT      = 2'd1;
    localparam logic [1:0] REG_DAMPING_Q16     = 2'd2;
    localparam logic [1:0] REG_ITERATION_COUNT = 2'd3;

    localparam logic KIND_RUN_DONE = 1'b0;
    localparam logic KIND_READ     = 1'b1;

    typedef struct packed {
        logic [10:0] vertex_count;
        logic [13:0] edge_count;
        logic [16:0] damping_q16;
        logic [7:0]  iteration_count;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD_ROW,
        OP_LOAD_EDGE,
        OP_READ,
        OP_RUN_SETUP,
        OP_INIT,
        OP_E_READ,
        OP_DEG_READ,
        OP_DEG_INC,
        OP_E_SKIP,
        OP_ITER_SETUP,
        OP_ROW_LO,
        OP_ROW_HI,
        OP_WIN,
        OP_EDGE_RD,
        OP_SRC_RD,
        OP_J_SKIP,
        OP_DIV_START,
        OP_ACC,
        OP_MUL_STEP,
        OP_WRITE,
        OP_DONE
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_DEG_EDGE,
        S_DEG_SRC,
        S_DEG_INC,
        S_ITER,
        S_ROW_LO,
        S_ROW_HI,
        S_WIN,
        S_EDGE,
        S_SRC,
        S_TERM,
        S_DIV,
        S_MUL,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic init_last;
        logic e_done;
        logic src_ok;
        logic deg_zero;
        logic j_lt_hi;
        logic div_done;
        logic mul_last;
        logic v_last;
        logic k_last;
        logic run_empty;
    } status_t;

endpackage

// ===== rtl/core/pagerank_pull_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pagerank_pull_csr
// Pull-style PageRank over a CSR in-edge graph, Q16.16 ranks.
//
//   channel   signals                                   handshake
//   command   start, cmd, index, value                  start & !busy
//   config    cfg_valid, cfg_index, cfg_data            cfg_valid & cfg_ready
//   result    result_strobe, kind, vertex, rank, sat'd  strobe, one cycle
//
// Loads never raise busy; a read result passes through the pending-read and
// output registers, and reads may be issued every cycle while busy is low.
// A run holds busy through an init sweep of all MAX_VERTICES entries, a
// degree count over the edges, then per iteration and vertex an in-edge walk
// with a serial divide of RANK_BITS (min 17) bits per counted edge.
// Reset clears control and sets config to its defaults; stores hold nothing
// until loaded or run. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module pagerank_pull_csr #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 8192,
    parameter int RANK_BITS    = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [12:0] index,
    input  logic [13:0] value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data,
    output logic        result_strobe,
    output logic        kind,
    output logic [9:0]  vertex,
    output logic [31:0] rank,
    output logic        saturated
);

    prpc_pkg::cfg_t    cfg_reg, cfg_next;
    prpc_pkg::op_t     op;
    prpc_pkg::status_t status;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prpc_pkg::REG_VERTEX_COUNT:    cfg_next.vertex_count    = cfg_data[10:0];
                prpc_pkg::REG_EDGE_COUNT:      cfg_next.edge_count      = cfg_data[13:0];
                prpc_pkg::REG_DAMPING_Q16:     cfg_next.damping_q16     = cfg_data;
                prpc_pkg::REG_ITERATION_COUNT: cfg_next.iteration_count = cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vertex_count    <= 11'd1;
            cfg_reg.edge_count      <= 14'd0;
            cfg_reg.damping_q16     <= 17'd55706;
            cfg_reg.iteration_count <= 8'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prpc_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .cmd(cmd),
        .status(status), .op(op), .busy(busy)
    );

    prpc_dp #(
        .MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .RANK_BITS(RANK_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .op(op), .cfg(cfg_reg), .index(index), .value(value),
        .status(status), .result_strobe(result_strobe), .kind(kind), .vertex(vertex),
        .rank(rank), .saturated(saturated)
    );

    a_run_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && cmd == prpc_pkg::CMD_RUN |=> busy)
        else $error("run request did not start the sequencer");

    a_busy_end_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_strobe && kind == prpc_pkg::KIND_RUN_DONE)
        else $error("run ended without a done result");

    a_done_only_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && kind == prpc_pkg::KIND_RUN_DONE |-> $past(busy))
        else $error("done result outside a run");

endmodule

// ===== rtl/core/prpc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module prpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/prpc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prpc_div #(
    parameter int DIVIDEND_W = 32,
    parameter int DIVISOR_W  = 14
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W:0]    shifted;
    logic                  ge;

    assign shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? DIVISOR_W'(shifted - {1'b0, dvs_reg}) : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/prpc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpc_dp
// Datapath: graph and rank stores, walk counters, divider, sum and damping.
// ----------------------------------------------------------------------------
module prpc_dp #(
    parameter int MAX_VERTICES = 1024,
    parameter int MAX_EDGES    = 8192,
    parameter int RANK_BITS    = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  prpc_pkg::op_t                op,
    input  prpc_pkg::cfg_t               cfg,
    input  logic [prpc_pkg::INDEX_W-1:0] index,
    input  logic [prpc_pkg::VALUE_W-1:0] value,
    output prpc_pkg::status_t            status,
    output logic                         result_strobe,
    output logic                         kind,
    output logic [9:0]                   vertex,
    output logic [31:0]                  rank,
    output logic                         saturated
);

    localparam int VI_W  = $clog2(MAX_VERTICES);
    localparam int VC_W  = $clog2(MAX_VERTICES + 1);
    localparam int EI_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EC_W  = $clog2(MAX_EDGES + 1);
    localparam int J_W   = (EC_W > prpc_pkg::VALUE_W) ? EC_W : prpc_pkg::VALUE_W;
    localparam int RS_W  = (RANK_BITS > 17) ? RANK_BITS : 17;
    localparam int SUM_W = 63;
    localparam int ACC_W = 81;
    localparam int RES_W = 66;
    localparam logic [63:0] SUM_CAP = 64'h4000_0000_0000_0000;

    logic [VC_W-1:0]  nv_reg, nv_next;
    logic [EC_W-1:0]  ne_reg, ne_next;
    logic [16:0]      d_reg, d_next;
    logic [7:0]       iter_reg, iter_next;
    logic [VI_W-1:0]  cnt_reg, cnt_next;
    logic [EC_W-1:0]  e_reg, e_next;
    logic [VC_W-1:0]  v_reg, v_next;
    logic [7:0]       k_reg, k_next;
    logic [J_W-1:0]   j_reg, j_next;
    logic [J_W-1:0]   hi_reg, hi_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [1:0]       step_reg, step_next;
    logic             sat_reg, sat_next;
    logic             final_odd_reg, final_odd_next;
    logic             rd_pend_reg, rd_pend_next;
    logic [9:0]       rd_vertex_reg, rd_vertex_next;
    logic             rd_inrange_reg, rd_inrange_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [9:0]       out_vertex_reg, out_vertex_next;
    logic [31:0]      out_rank_reg, out_rank_next;
    logic             out_sat_reg, out_sat_next;

    logic                         row_we, row_re;
    logic [VI_W-1:0]              row_waddr, row_raddr;
    logic [prpc_pkg::VALUE_W-1:0] row_rdata;
    logic                         edge_we, edge_re;
    logic [EI_W-1:0]              edge_waddr, edge_raddr;
    logic [prpc_pkg::VALUE_W-1:0] edge_rdata;
    logic                         deg_we, deg_re;
    logic [VI_W-1:0]              deg_waddr, deg_raddr;
    logic [EC_W-1:0]              deg_wdata, deg_rdata;
    logic                         even_we, odd_we, rank_re;
    logic [VI_W-1:0]              rank_waddr, rank_raddr;
    logic [RS_W-1:0]              rank_wdata, even_rdata, odd_rdata;

    logic             div_start, div_done;
    logic [RS_W-1:0]  quotient;

    logic [31:0]      idx32, src32;
    logic [VC_W-1:0]  vp1;
    logic [J_W-1:0]   ne_j, hi_raw;
    logic [63:0]      tsum, sum_pad, chunk_sh, r64;
    logic [32:0]      prod;
    logic [RES_W-1:0] res;
    logic             res_sat;

    assign idx32    = 32'(index);
    assign src32    = 32'(edge_rdata);
    assign vp1      = v_reg + VC_W'(1);
    assign ne_j     = J_W'(ne_reg);
    assign hi_raw   = status.v_last ? ne_j : J_W'(row_rdata);
    assign tsum     = {1'b0, sum_reg} + 64'(quotient);
    assign sum_pad  = {1'b0, sum_reg};
    assign chunk_sh = sum_pad >> {~step_reg, 4'b0000};
    assign prod     = chunk_sh[15:0] * d_reg;
    assign res      = RES_W'(17'd65536 - d_reg) + RES_W'(acc_reg[ACC_W-1:16]);
    assign res_sat  = |res[RES_W-1:RANK_BITS];
    assign r64      = 64'(final_odd_reg ? odd_rdata : even_rdata);

    assign status.init_last = cnt_reg == VI_W'(MAX_VERTICES - 1);
    assign status.e_done    = e_reg == ne_reg;
    assign status.src_ok    = src32 < 32'(nv_reg);
    assign status.deg_zero  = deg_rdata == '0;
    assign status.j_lt_hi   = j_reg < hi_reg;
    assign status.div_done  = div_done;
    assign status.mul_last  = step_reg == 2'd3;
    assign status.v_last    = vp1 == nv_reg;
    assign status.k_last    = (k_reg + 8'd1) == iter_reg;
    assign status.run_empty = (iter_reg == 8'd0) || (nv_reg == '0);

    // RAM port steering
    always_comb
    begin
        row_we     = op == prpc_pkg::OP_LOAD_ROW && idx32 < 32'(MAX_VERTICES);
        row_waddr  = idx32[VI_W-1:0];
        row_re     = op == prpc_pkg::OP_ROW_LO || op == prpc_pkg::OP_ROW_HI;
        row_raddr  = (op == prpc_pkg::OP_ROW_HI) ? vp1[VI_W-1:0] : v_reg[VI_W-1:0];

        edge_we    = op == prpc_pkg::OP_LOAD_EDGE && idx32 < 32'(MAX_EDGES);
        edge_waddr = idx32[EI_W-1:0];
        edge_re    = op == prpc_pkg::OP_E_READ || op == prpc_pkg::OP_EDGE_RD;
        edge_raddr = (op == prpc_pkg::OP_E_READ) ? e_reg[EI_W-1:0] : j_reg[EI_W-1:0];

        deg_we     = op == prpc_pkg::OP_INIT || op == prpc_pkg::OP_DEG_INC;
        deg_waddr  = (op == prpc_pkg::OP_INIT) ? cnt_reg : src32[VI_W-1:0];
        deg_wdata  = (op == prpc_pkg::OP_INIT) ? '0 : deg_rdata + EC_W'(1);
        deg_re     = op == prpc_pkg::OP_DEG_READ || op == prpc_pkg::OP_SRC_RD;
        deg_raddr  = src32[VI_W-1:0];

        even_we    = op == prpc_pkg::OP_INIT || (op == prpc_pkg::OP_WRITE && k_reg[0]);
        odd_we     = op == prpc_pkg::OP_INIT || (op == prpc_pkg::OP_WRITE && !k_reg[0]);
        rank_waddr = (op == prpc_pkg::OP_INIT) ? cnt_reg : v_reg[VI_W-1:0];
        if (op == prpc_pkg::OP_INIT)
        begin
            rank_wdata = RS_W'(17'd65536);
        end
        else if (res_sat)
        begin
            rank_wdata = RS_W'({RANK_BITS{1'b1}});
        end
        else
        begin
            rank_wdata = res[RS_W-1:0];
        end
        rank_re    = op == prpc_pkg::OP_SRC_RD || op == prpc_pkg::OP_READ;
        rank_raddr = (op == prpc_pkg::OP_READ) ? idx32[VI_W-1:0] : src32[VI_W-1:0];

        div_start  = op == prpc_pkg::OP_DIV_START;
    end

    always_comb
    begin
        nv_next         = nv_reg;
        ne_next         = ne_reg;
        d_next          = d_reg;
        iter_next       = iter_reg;
        cnt_next        = cnt_reg;
        e_next          = e_reg;
        v_next          = v_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        hi_next         = hi_reg;
        sum_next        = sum_reg;
        acc_next        = acc_reg;
        step_next       = step_reg;
        sat_next        = sat_reg;
        final_odd_next  = final_odd_reg;
        rd_pend_next    = 1'b0;
        rd_vertex_next  = rd_vertex_reg;
        rd_inrange_next = rd_inrange_reg;
        out_valid_next  = 1'b0;
        out_kind_next   = out_kind_reg;
        out_vertex_next = out_vertex_reg;
        out_rank_next   = out_rank_reg;
        out_sat_next    = out_sat_reg;

        // finish a pending read
        if (rd_pend_reg)
        begin
            out_valid_next  = 1'b1;
            out_kind_next   = prpc_pkg::KIND_READ;
            out_vertex_next = rd_vertex_reg;
            out_rank_next   = rd_inrange_reg ? r64[31:0] : 32'd0;
            out_sat_next    = sat_reg;
        end

        case (op)
            prpc_pkg::OP_READ:
            begin
                rd_pend_next    = 1'b1;
                rd_vertex_next  = index[9:0];
                rd_inrange_next = idx32 < 32'(MAX_VERTICES);
            end
            prpc_pkg::OP_RUN_SETUP:
            begin
                nv_next   = (32'(cfg.vertex_count) > 32'(MAX_VERTICES)) ?
                            VC_W'(MAX_VERTICES) : VC_W'(cfg.vertex_count);
                ne_next   = (32'(cfg.edge_count) > 32'(MAX_EDGES)) ?
                            EC_W'(MAX_EDGES) : EC_W'(cfg.edge_count);
                d_next    = (cfg.damping_q16 > 17'd65536) ? 17'd65536 : cfg.damping_q16;
                iter_next = cfg.iteration_count;
                cnt_next  = '0;
                e_next    = '0;
                sat_next  = 1'b0;
            end
            prpc_pkg::OP_INIT:
            begin
                cnt_next = cnt_reg + VI_W'(1);
            end
            prpc_pkg::OP_DEG_INC,
            prpc_pkg::OP_E_SKIP:
            begin
                e_next = e_reg + EC_W'(1);
            end
            prpc_pkg::OP_ITER_SETUP:
            begin
                v_next = '0;
                k_next = '0;
            end
            prpc_pkg::OP_ROW_HI:
            begin
                j_next = J_W'(row_rdata);
            end
            prpc_pkg::OP_WIN:
            begin
                hi_next   = (hi_raw > ne_j) ? ne_j : hi_raw;
                sum_next  = '0;
                acc_next  = '0;
                step_next = '0;
            end
            prpc_pkg::OP_J_SKIP:
            begin
                j_next = j_reg + J_W'(1);
            end
            prpc_pkg::OP_ACC:
            begin
                j_next = j_reg + J_W'(1);
                if (tsum >= SUM_CAP)
                begin
                    sum_next = SUM_CAP[SUM_W-1:0];
                    sat_next = 1'b1;
                end
                else
                begin
                    sum_next = tsum[SUM_W-1:0];
                end
            end
            prpc_pkg::OP_MUL_STEP:
            begin
                acc_next  = {acc_reg[ACC_W-17:0], 16'h0000} + ACC_W'(prod);
                step_next = step_reg + 2'd1;
            end
            prpc_pkg::OP_WRITE:
            begin
                if (res_sat)
                begin
                    sat_next = 1'b1;
                end
                if (status.v_last)
                begin
                    v_next = '0;
                    k_next = k_reg + 8'd1;
                end
                else
                begin
                    v_next = vp1;
                end
            end
            prpc_pkg::OP_DONE:
            begin
                final_odd_next  = iter_reg[0];
                out_valid_next  = 1'b1;
                out_kind_next   = prpc_pkg::KIND_RUN_DONE;
                out_vertex_next = '0;
                out_rank_next   = '0;
                out_sat_next    = sat_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg       <= 1'b0;
            final_odd_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sat_reg       <= sat_next;
            final_odd_reg <= final_odd_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        nv_reg         <= nv_next;
        ne_reg         <= ne_next;
        d_reg          <= d_next;
        iter_reg       <= iter_next;
        cnt_reg        <= cnt_next;
        e_reg          <= e_next;
        v_reg          <= v_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        hi_reg         <= hi_next;
        sum_reg        <= sum_next;
        acc_reg        <= acc_next;
        step_reg       <= step_next;
        rd_vertex_reg  <= rd_vertex_next;
        rd_inrange_reg <= rd_inrange_next;
        out_kind_reg   <= out_kind_next;
        out_vertex_reg <= out_vertex_next;
        out_rank_reg   <= out_rank_next;
        out_sat_reg    <= out_sat_next;
    end

    prpc_ram #(.WIDTH(prpc_pkg::VALUE_W), .DEPTH(MAX_VERTICES)) u_row_ram (
        .clk(clk), .we(row_we), .waddr(row_waddr), .wdata(value),
        .re(row_re), .raddr(row_raddr), .rdata(row_rdata)
    );

    prpc_ram #(.WIDTH(prpc_pkg::VALUE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(value),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
    );

    prpc_ram #(.WIDTH(EC_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
        .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
        .re(deg_re), .raddr(deg_raddr), .rdata(deg_rdata)
    );

    prpc_ram #(.WIDTH(RS_W), .DEPTH(MAX_VERTICES)) u_even_ram (
        .clk(clk), .we(even_we), .waddr(rank_waddr), .wdata(rank_wdata),
        .re(rank_re), .raddr(rank_raddr), .rdata(even_rdata)
    );

    prpc_ram #(.WIDTH(RS_W), .DEPTH(MAX_VERTICES)) u_odd_ram (
        .clk(clk), .we(odd_we), .waddr(rank_waddr), .wdata(rank_wdata),
        .re(rank_re), .raddr(rank_raddr), .rdata(odd_rdata)
    );

    prpc_div #(.DIVIDEND_W(RS_W), .DIVISOR_W(EC_W)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(k_reg[0] ? odd_rdata : even_rdata), .divisor(deg_rdata),
        .done(div_done), .quotient(quotient)
    );

    assign result_strobe = out_valid_reg;
    assign kind          = out_kind_reg;
    assign vertex        = out_vertex_reg;
    assign rank          = out_rank_reg;
    assign saturated     = out_sat_reg;

endmodule

// ===== rtl/core/prpc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpc_ctrl
// Sequencer: command decode, init sweep, degree count and rank iterations.
// ----------------------------------------------------------------------------
module prpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        cmd,
    input  prpc_pkg::status_t status,
    output prpc_pkg::op_t     op,
    output logic              busy
);

    prpc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prpc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op         = prpc_pkg::OP_NONE;
        case (state_reg)
            prpc_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        prpc_pkg::CMD_LOAD_ROW:  op = prpc_pkg::OP_LOAD_ROW;
                        prpc_pkg::CMD_LOAD_EDGE: op = prpc_pkg::OP_LOAD_EDGE;
                        prpc_pkg::CMD_READ:      op = prpc_pkg::OP_READ;
                        default:
                        begin
                            op         = prpc_pkg::OP_RUN_SETUP;
                            state_next = prpc_pkg::S_INIT;
                        end
                    endcase
                end
            end
            prpc_pkg::S_INIT:
            begin
                op = prpc_pkg::OP_INIT;
                if (status.init_last)
                begin
                    state_next = prpc_pkg::S_DEG_EDGE;
                end
            end
            prpc_pkg::S_DEG_EDGE:
            begin
                if (status.e_done)
                begin
                    state_next = prpc_pkg::S_ITER;
                end
                else
                begin
                    op         = prpc_pkg::OP_E_READ;
                    state_next = prpc_pkg::S_DEG_SRC;
                end
            end
            prpc_pkg::S_DEG_SRC:
            begin
                if (status.src_ok)
                begin
                    op         = prpc_pkg::OP_DEG_READ;
                    state_next = prpc_pkg::S_DEG_INC;
                end
                else
                begin
                    op         = prpc_pkg::OP_E_SKIP;
                    state_next = prpc_pkg::S_DEG_EDGE;
                end
            end
            prpc_pkg::S_DEG_INC:
            begin
                op         = prpc_pkg::OP_DEG_INC;
                state_next = prpc_pkg::S_DEG_EDGE;
            end
            prpc_pkg::S_ITER:
            begin
                op         = prpc_pkg::OP_ITER_SETUP;
                state_next = status.run_empty ? prpc_pkg::S_DONE : prpc_pkg::S_ROW_LO;
            end
            prpc_pkg::S_ROW_LO:
            begin
                op         = prpc_pkg::OP_ROW_LO;
                state_next = prpc_pkg::S_ROW_HI;
            end
            prpc_pkg::S_ROW_HI:
            begin
                op         = prpc_pkg::OP_ROW_HI;
                state_next = prpc_pkg::S_WIN;
            end
            prpc_pkg::S_WIN:
            begin
                op         = prpc_pkg::OP_WIN;
                state_next = prpc_pkg::S_EDGE;
            end
            prpc_pkg::S_EDGE:
            begin
                if (status.j_lt_hi)
                begin
                    op         = prpc_pkg::OP_EDGE_RD;
                    state_next = prpc_pkg::S_SRC;
                end
                else
                begin
                    state_next = prpc_pkg::S_MUL;
                end
            end
            prpc_pkg::S_SRC:
            begin
                if (status.src_ok)
                begin
                    op         = prpc_pkg::OP_SRC_RD;
                    state_next = prpc_pkg::S_TERM;
                end
                else
                begin
                    op         = prpc_pkg::OP_J_SKIP;
                    state_next = prpc_pkg::S_EDGE;
                end
            end
            prpc_pkg::S_TERM:
            begin
                if (status.deg_zero)
                begin
                    op         = prpc_pkg::OP_J_SKIP;
                    state_next = prpc_pkg::S_EDGE;
                end
                else
                begin
                    op         = prpc_pkg::OP_DIV_START;
                    state_next = prpc_pkg::S_DIV;
                end
            end
            prpc_pkg::S_DIV:
            begin
                if (status.div_done)
                begin
                    op         = prpc_pkg::OP_ACC;
                    state_next = prpc_pkg::S_EDGE;
                end
            end
            prpc_pkg::S_MUL:
            begin
                op = prpc_pkg::OP_MUL_STEP;
                if (status.mul_last)
                begin
                    state_next = prpc_pkg::S_WRITE;
                end
            end
            prpc_pkg::S_WRITE:
            begin
                op = prpc_pkg::OP_WRITE;
                if (status.v_last && status.k_last)
                begin
                    state_next = prpc_pkg::S_DONE;
                end
                else
                begin
                    state_next = prpc_pkg::S_ROW_LO;
                end
            end
            prpc_pkg::S_DONE:
            begin
                op         = prpc_pkg::OP_DONE;
                state_next = prpc_pkg::S_IDLE;
            end
            default:
            begin
                state_next = prpc_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = state_reg != prpc_pkg::S_IDLE;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pull-style CSR PageRank engine.
//
// Checks the engine in two parts. A short table covers the extremes: reset
// values, out-of-range loads and reads, and the ranks just after a run. Then
// random phases follow. Each phase writes all four registers, loads a small
// graph mixed with stray loads and reads, runs it, and reads back ranks.
// An internal rank predictor gives the expected value of every run and read
// request that the table does not check itself. A monitor compares each
// result strobe with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic [1:0]  c;
        logic [12:0] i;
        logic [13:0] v;
    } request_t;

    typedef struct packed {
        logic        k;
        logic [9:0]  vx;
        logic [31:0] rk;
        logic        s;
    } rank_result_t;

    typedef struct packed {
        logic [1:0]  c;
        logic [12:0] i;
        logic [13:0] v;
        logic        chk;
        logic [31:0] rk;
    } table_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  cmd = prpc_pkg::CMD_LOAD_ROW;
    logic [12:0] index = '0;
    logic [13:0] value = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = prpc_pkg::REG_VERTEX_COUNT;
    logic [16:0] cfg_data = '0;
    logic        result_strobe;
    logic        kind;
    logic [9:0]  vertex;
    logic [31:0] rank;
    logic        saturated;

    pagerank_pull_csr u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cmd(cmd), .index(index), .value(value),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .result_strobe(result_strobe), .kind(kind), .vertex(vertex),
        .rank(rank), .saturated(saturated)
    );

    always #1 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // rank predictor state
    logic [10:0]     p_nv = 11'd1;
    logic [13:0]     p_ne = 14'd0;
    logic [16:0]     p_damp = 17'd55706;
    logic [7:0]      p_iter = 8'd10;
    logic [13:0]     row_mem [1024];
    logic [13:0]     src_mem [8192];
    int unsigned     out_deg [1024];
    longint unsigned rank_a [1024];
    longint unsigned rank_b [1024];
    logic            sat_seen = 1'b0;
    logic            ends_in_b = 1'b0;

    rank_result_t pending_ranks [$];
    int           fails = 0;
    int           sent = 0;
    bit           allow_idle = 1'b1;

    function automatic longint unsigned pull_rank(int v, int nv, int ne, longint unsigned d,
                                                  bit from_b);
        longint unsigned sum;
        longint unsigned t;
        longint unsigned res;
        longint unsigned cap;
        int lo;
        int hi;
        int s;
        cap = 64'd1 << 62;
        sum = 0;
        lo = row_mem[v];
        hi = (v + 1 == nv) ? ne : row_mem[v + 1];
        if (hi > ne)
            hi = ne;
        for (int j = lo; j < hi; j++)
        begin
            s = src_mem[j];
            if (s >= nv || out_deg[s] == 0)
                continue;
            t = (from_b ? rank_b[s] : rank_a[s]) / out_deg[s];
            if (t >= cap - sum)
            begin
                sum = cap;
                sat_seen = 1'b1;
            end
            else
                sum += t;
        end
        res = (64'd65536 - d) + (sum >> 16) * d + (((sum & 64'hFFFF) * d) >> 16);
        if (res > 64'hFFFF_FFFF)
        begin
            res = 64'hFFFF_FFFF;
            sat_seen = 1'b1;
        end
        return res;
    endfunction

    function automatic void run_ranks();
        int nv;
        int ne;
        longint unsigned d;
        nv = (p_nv > 1024) ? 1024 : p_nv;
        ne = (p_ne > 8192) ? 8192 : p_ne;
        d = (p_damp > 65536) ? 65536 : p_damp;
        for (int i = 0; i < 1024; i++)
        begin
            out_deg[i] = 0;
            rank_a[i] = 65536;
            rank_b[i] = 65536;
        end
        for (int i = 0; i < ne; i++)
            if (src_mem[i] < nv)
                out_deg[src_mem[i]]++;
        sat_seen = 1'b0;
        for (int k = 0; k < p_iter; k++)
            for (int i = 0; i < nv; i++)
                if (k % 2 == 1)
                    rank_a[i] = pull_rank(i, nv, ne, d, 1'b1);
                else
                    rank_b[i] = pull_rank(i, nv, ne, d, 1'b0);
        ends_in_b = p_iter[0];
    endfunction

    function automatic bit rank_step(request_t r, output rank_result_t e);
        e = '0;
        case (r.c)
            prpc_pkg::CMD_LOAD_ROW:
            begin
                if (r.i < 1024)
                    row_mem[r.i] = r.v;
                return 1'b0;
            end
            prpc_pkg::CMD_LOAD_EDGE:
            begin
                src_mem[r.i] = r.v;
                return 1'b0;
            end
            prpc_pkg::CMD_RUN:
            begin
                run_ranks();
                e.k = prpc_pkg::KIND_RUN_DONE;
                e.s = sat_seen;
                return 1'b1;
            end
            default:
            begin
                e.k = prpc_pkg::KIND_READ;
                e.vx = r.i[9:0];
                if (r.i < 1024)
                    e.rk = ends_in_b ? rank_b[r.i][31:0] : rank_a[r.i][31:0];
                e.s = sat_seen;
                return 1'b1;
            end
        endcase
    endfunction

    always @(posedge clk)
    begin
        rank_result_t e;
        if (result_strobe)
        begin
            if (pending_ranks.size() == 0)
            begin
                $error("unexpected result kind=%0d vertex=%0d", kind, vertex);
                fails++;
            end
            else
            begin
                e = pending_ranks.pop_front();
                if (kind !== e.k)
                begin
                    $error("kind: expected %0d actual %0d", e.k, kind);
                    fails++;
                end
                if (vertex !== e.vx)
                begin
                    $error("vertex: expected %0d actual %0d", e.vx, vertex);
                    fails++;
                end
                if (rank !== e.rk)
                begin
                    $error("rank: expected %0h actual %0h", e.rk, rank);
                    fails++;
                end
                if (saturated !== e.s)
                begin
                    $error("saturated: expected %0d actual %0d", e.s, saturated);
                    fails++;
                end
            end
        end
    end

    task automatic send_request(request_t r, bit typed, rank_result_t typed_exp);
        rank_result_t e;
        int gap;
        if (allow_idle && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= r.c;
        index <= r.i;
        value <= r.v;
        // busy only moves at the rising edge, so the falling edge sees a settled value
        while (busy)
            @(negedge clk);
        @(posedge clk);
        if (rank_step(r, e))
            pending_ranks.push_back(typed ? typed_exp : e);
        sent++;
    endtask

    task automatic drain_ranks();
        @(negedge clk);
        start <= 1'b0;
        while (pending_ranks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            prpc_pkg::REG_VERTEX_COUNT: p_nv = data[10:0];
            prpc_pkg::REG_EDGE_COUNT:   p_ne = data[13:0];
            prpc_pkg::REG_DAMPING_Q16:  p_damp = data;
            default:                    p_iter = data[7:0];
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int nv, int ne, int damp, int iters);
        request_t     plan [$];
        request_t     r;
        request_t     tmp;
        rank_result_t none;
        int           nvc;
        int           off;
        int           k;
        none = '0;
        drain_ranks();
        write_reg(prpc_pkg::REG_VERTEX_COUNT, 17'(nv));
        write_reg(prpc_pkg::REG_EDGE_COUNT, 17'(ne));
        write_reg(prpc_pkg::REG_DAMPING_Q16, 17'(damp));
        write_reg(prpc_pkg::REG_ITERATION_COUNT, 17'(iters));
        nvc = (nv > 1024) ? 1024 : nv;
        off = 0;
        if (iters > 0)
            for (int v = 0; v < nvc; v++)
            begin
                r.c = prpc_pkg::CMD_LOAD_ROW;
                r.i = 13'(v);
                if ($urandom_range(0, 6) == 0)
                    r.v = 14'($urandom_range(0, 16383));
                else
                begin
                    r.v = 14'(off);
                    off += $urandom_range(0, 2 * ne / (nvc + 1) + 1);
                end
                plan.push_back(r);
            end
        for (int j = 0; j < ne; j++)
        begin
            r.c = prpc_pkg::CMD_LOAD_EDGE;
            r.i = 13'(j);
            if ($urandom_range(0, 9) == 0 || nvc == 0)
                r.v = 14'($urandom_range(0, 16383));
            else
                r.v = 14'($urandom_range(0, nvc - 1));
            plan.push_back(r);
        end
        repeat ($urandom_range(0, 4))
        begin
            r.c = $urandom_range(0, 1) ? prpc_pkg::CMD_LOAD_ROW : prpc_pkg::CMD_LOAD_EDGE;
            r.i = (r.c == prpc_pkg::CMD_LOAD_ROW) ? 13'($urandom_range(1024, 8191))
                                                  : 13'($urandom_range(0, 8191));
            r.v = 14'($urandom_range(0, 16383));
            plan.push_back(r);
        end
        repeat ($urandom_range(0, 3))
        begin
            r.c = prpc_pkg::CMD_READ;
            r.i = 13'($urandom_range(0, 8191));
            r.v = 14'($urandom_range(0, 16383));
            plan.push_back(r);
        end
        for (int a = plan.size() - 1; a > 0; a--)
        begin
            k = $urandom_range(0, a);
            tmp = plan[a];
            plan[a] = plan[k];
            plan[k] = tmp;
        end
        r.c = prpc_pkg::CMD_RUN;
        r.i = 13'($urandom_range(0, 8191));
        r.v = 14'($urandom_range(0, 16383));
        plan.push_back(r);
        repeat ($urandom_range(3, 12))
        begin
            r.c = prpc_pkg::CMD_READ;
            r.i = ($urandom_range(0, 4) == 0 || nvc == 0) ? 13'($urandom_range(0, 8191))
                                                          : 13'($urandom_range(0, nvc - 1));
            r.v = 14'($urandom_range(0, 16383));
            plan.push_back(r);
        end
        foreach (plan[n])
            send_request(plan[n], 1'b0, none);
    endtask

    initial
    begin
        table_row_t   rows [13];
        rank_result_t e;
        request_t     r;
        int           nv;
        int           ne;
        int           damp;
        int           iters;
        rows = '{
            '{prpc_pkg::CMD_LOAD_ROW,  13'd0,    14'd0,     1'b0, 32'd0},
            '{prpc_pkg::CMD_RUN,       13'd0,    14'd0,     1'b1, 32'd0},
            '{prpc_pkg::CMD_READ,      13'd0,    14'd0,     1'b1, 32'd9830},
            '{prpc_pkg::CMD_READ,      13'd1023, 14'd16383, 1'b1, 32'd65536},
            '{prpc_pkg::CMD_READ,      13'd1024, 14'd0,     1'b1, 32'd0},
            '{prpc_pkg::CMD_READ,      13'd8191, 14'd0,     1'b1, 32'd0},
            '{prpc_pkg::CMD_LOAD_ROW,  13'd1024, 14'd16383, 1'b0, 32'd0},
            '{prpc_pkg::CMD_LOAD_ROW,  13'd8191, 14'd0,     1'b0, 32'd0},
            '{prpc_pkg::CMD_LOAD_EDGE, 13'd8191, 14'd16383, 1'b0, 32'd0},
            '{prpc_pkg::CMD_LOAD_EDGE, 13'd0,    14'd0,     1'b0, 32'd0},
            '{prpc_pkg::CMD_READ,      13'd0,    14'd0,     1'b1, 32'd9830},
            '{prpc_pkg::CMD_RUN,       13'd8191, 14'd16383, 1'b1, 32'd0},
            '{prpc_pkg::CMD_READ,      13'd5,    14'd0,     1'b0, 32'd0}
        };
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (rows[n])
        begin
            r = '{rows[n].c, rows[n].i, rows[n].v};
            e.k = (rows[n].c == prpc_pkg::CMD_RUN) ? prpc_pkg::KIND_RUN_DONE
                                                    : prpc_pkg::KIND_READ;
            e.vx = (rows[n].c == prpc_pkg::CMD_RUN) ? 10'd0 : rows[n].i[9:0];
            e.rk = rows[n].rk;
            e.s = 1'b0;
            send_request(r, rows[n].chk, e);
        end
        run_phase(2047, 0, 0, 0);
        run_phase(0, 0, 65536, 0);
        run_phase(1024, 3, 131071, 0);
        run_phase(2, 4, 65535, 255);
        run_phase(1, 2, 65536, 1);
        while (sent < 1550)
        begin
            allow_idle = (sent < 1400);
            case ($urandom_range(0, 9))
                0:
                begin
                    nv = $urandom_range(13, 2047);
                    ne = $urandom_range(0, 40);
                    iters = 0;
                end
                1:
                begin
                    nv = $urandom_range(1, 3);
                    ne = $urandom_range(0, 4);
                    iters = 255;
                end
                default:
                begin
                    nv = $urandom_range(1, 12);
                    ne = $urandom_range(0, 40);
                    iters = $urandom_range(1, 12);
                end
            endcase
            case ($urandom_range(0, 5))
                0:       damp = 0;
                1:       damp = 65536;
                2:       damp = $urandom_range(65537, 131071);
                default: damp = $urandom_range(0, 65535);
            endcase
            run_phase(nv, ne, damp, iters);
        end
        drain_ranks();
        repeat (20) @(posedge clk);
        if (fails == 0 && pending_ranks.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== pagerank_pull_csr.f =====
rtl/core/prpc_pkg.sv
rtl/core/prpc_ram.sv
rtl/core/prpc_div.sv
rtl/core/prpc_dp.sv
rtl/core/prpc_ctrl.sv
rtl/core/pagerank_pull_csr.sv
sim/tb_top.sv
